/* design/tegl_pkg.sv */
package tegl_pkg;

  // Pen arithmetic width; the coordinate ports stay 12 bits wide.
  localparam int COORD_BITS    = 12;
  localparam int OUT_COORD_W   = 12;
  localparam int GLYPH_ADVANCE = 6;
  localparam int LINE_ADVANCE  = 9;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLED    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_COLOR = 2'd3;

  localparam logic [31:0] BASE_COLOR_RESET = 32'hFFFF_FFFF;

  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // Atlas cell of the question mark, used for every byte not in the atlas.
  localparam logic [3:0] QMARK_COL = 4'd13;
  localparam logic [3:0] QMARK_ROW = 4'd14;

  typedef struct packed {
    logic [3:0] col;
    logic [3:0] row;
  } glyph_cell_t;

endpackage

/* design/tegl_glyph_rom.sv */
module tegl_glyph_rom import tegl_pkg::*; (
  input  logic [7:0]  ch,
  output glyph_cell_t glyph
);

  logic [7:0] uc;

  always_comb begin
    // Lower case folds onto the upper case cells.
    uc = ((ch >= "a") && (ch <= "z")) ? (ch - 8'd32) : ch;
    glyph.col = QMARK_COL;
    glyph.row = QMARK_ROW;
    if ((uc >= "A") && (uc <= "P")) begin
      glyph.col = 4'(uc - "A");
      glyph.row = 4'd15;
    end else if ((uc >= "Q") && (uc <= "Z")) begin
      glyph.col = 4'(uc - "Q");
      glyph.row = 4'd14;
    end else if ((uc >= "0") && (uc <= "9")) begin
      glyph.col = 4'(uc - "0");
      glyph.row = 4'd13;
    end else begin
      case (uc)
        ":":     begin glyph.col = 4'd10; glyph.row = 4'd14; end
        ".":     begin glyph.col = 4'd11; glyph.row = 4'd14; end
        ",":     begin glyph.col = 4'd12; glyph.row = 4'd14; end
        "?":     begin glyph.col = 4'd13; glyph.row = 4'd14; end
        "!":     begin glyph.col = 4'd14; glyph.row = 4'd14; end
        8'h27:   begin glyph.col = 4'd10; glyph.row = 4'd13; end
        8'h22:   begin glyph.col = 4'd11; glyph.row = 4'd13; end
        "(":     begin glyph.col = 4'd12; glyph.row = 4'd13; end
        ")":     begin glyph.col = 4'd13; glyph.row = 4'd13; end
        " ":     begin glyph.col = 4'd14; glyph.row = 4'd13; end
        default: begin glyph.col = QMARK_COL; glyph.row = QMARK_ROW; end
      endcase
    end
  end

endmodule

/* design/text_escape_glyph_layout_unit.sv */
// A result is registered and shown on the outputs the cycle after its byte is accepted.
// One byte per cycle while out_ready is high; a doubled glyph stalls the next byte until
// its main copy is taken and the register holds its shadow. Newline and escape bytes
// give no beat, but $ after an escape's $ gives a glyph, a cut-short escape an error beat.
// Reset (synchronous, rst_n low): registers return to their reset values, the parser is
// idle, the next byte starts a new string and the output register is empty.
module text_escape_glyph_layout_unit import tegl_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_text_byte,
  input  logic                          in_end_of_text,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [31:0]                   cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [3:0]                    out_atlas_col,
  output logic [3:0]                    out_atlas_row,
  output logic signed [OUT_COORD_W-1:0] out_pen_x_out,
  output logic signed [OUT_COORD_W-1:0] out_pen_y_out,
  output logic                          out_from_palette,
  output logic [31:0]                   out_color_word,
  output logic                          out_is_shadow,
  output logic                          out_bad_escape,
  output logic                          out_run_last
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_TENS  = 2'd1;
  localparam logic [1:0] PH_UNITS = 2'd2;

  typedef struct packed {
    logic [3:0]                   col;
    logic [3:0]                   row;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         from_pal;
    logic [31:0]                  color;
    logic                         shadow;
    logic                         bad;
    logic                         last;
  } result_t;

  // Configuration registers.
  logic signed [11:0] origin_x_r, origin_y_r;
  logic               doubled_r;
  logic [31:0]        base_color_r;

  // Parse state.
  logic signed [COORD_BITS-1:0] pen_x_r, pen_x_nxt, pen_y_r, pen_y_nxt;
  logic [1:0]                   phase_r, phase_nxt;
  logic [3:0]                   tens_r, tens_nxt;
  logic                         pal_active_r, pal_active_nxt;
  logic [6:0]                   pal_idx_r, pal_idx_nxt;
  logic                         open_r, open_nxt;

  // Output register.
  result_t res_r, new_res;
  logic    out_valid_r, pend_r;
  logic    emit, emit_pend;

  logic                         in_fire;
  logic signed [COORD_BITS-1:0] eff_x, eff_y, origin_x_c;
  logic [3:0]                   digit;
  glyph_cell_t                  glyph;

  tegl_glyph_rom u_rom (
    .ch    (in_text_byte),
    .glyph (glyph)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || (out_ready && !pend_r);
  assign in_fire   = in_valid && in_ready;

  assign origin_x_c = COORD_BITS'(origin_x_r);
  assign eff_x      = open_r ? pen_x_r : origin_x_c;
  assign eff_y      = open_r ? pen_y_r : COORD_BITS'(origin_y_r);

  // Escape digits clamp to 0..9; in range the low nibble of the byte is the digit.
  assign digit = (in_text_byte < "0") ? 4'd0 :
                 (in_text_byte > "9") ? 4'd9 : in_text_byte[3:0];

  always_comb begin
    pen_x_nxt      = pen_x_r;
    pen_y_nxt      = pen_y_r;
    phase_nxt      = phase_r;
    tens_nxt       = tens_r;
    pal_active_nxt = pal_active_r;
    pal_idx_nxt    = pal_idx_r;
    open_nxt       = open_r;
    emit           = 1'b0;
    emit_pend      = 1'b0;

    new_res.col      = glyph.col;
    new_res.row      = glyph.row;
    new_res.x        = eff_x;
    new_res.y        = eff_y;
    new_res.from_pal = pal_active_r;
    new_res.color    = pal_active_r ? {25'd0, pal_idx_r} : base_color_r;
    new_res.shadow   = 1'b0;
    new_res.bad      = 1'b0;
    new_res.last     = !doubled_r;

    if (in_fire) begin
      pen_x_nxt = eff_x;
      pen_y_nxt = eff_y;
      open_nxt  = 1'b1;
      case (phase_r)
        PH_TENS: begin
          if (in_text_byte == CH_DOLLAR) begin
            phase_nxt = PH_IDLE;
            emit      = 1'b1;
            emit_pend = doubled_r;
            pen_x_nxt = eff_x + COORD_BITS'(GLYPH_ADVANCE);
          end else begin
            tens_nxt  = digit;
            phase_nxt = PH_UNITS;
            if (in_end_of_text) begin
              // String ends inside a color escape: one error beat, no glyph.
              emit        = 1'b1;
              new_res.col = 4'd0;
              new_res.row = 4'd0;
              new_res.bad = 1'b1;
              new_res.last = 1'b1;
            end
          end
        end
        PH_UNITS: begin
          pal_idx_nxt    = 7'({3'd0, tens_r} * 7'd10) + {3'd0, digit};
          pal_active_nxt = 1'b1;
          phase_nxt      = PH_IDLE;
        end
        default: begin
          if (in_text_byte == CH_NEWLINE) begin
            pen_y_nxt = eff_y - COORD_BITS'(LINE_ADVANCE);
            pen_x_nxt = origin_x_c;
          end else if ((in_text_byte == CH_DOLLAR) && !in_end_of_text) begin
            phase_nxt = PH_TENS;
          end else begin
            emit      = 1'b1;
            emit_pend = doubled_r;
            pen_x_nxt = eff_x + COORD_BITS'(GLYPH_ADVANCE);
          end
        end
      endcase
      if (in_end_of_text) begin
        phase_nxt      = PH_IDLE;
        tens_nxt       = 4'd0;
        pal_active_nxt = 1'b0;
        pal_idx_nxt    = 7'd0;
        open_nxt       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r   <= '0;
      origin_y_r   <= '0;
      doubled_r    <= 1'b0;
      base_color_r <= BASE_COLOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ORIGIN_X:   origin_x_r   <= cfg_data[11:0];
        REG_ORIGIN_Y:   origin_y_r   <= cfg_data[11:0];
        REG_DOUBLED:    doubled_r    <= cfg_data[0];
        REG_BASE_COLOR: base_color_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r      <= '0;
      pen_y_r      <= '0;
      phase_r      <= PH_IDLE;
      tens_r       <= '0;
      pal_active_r <= 1'b0;
      pal_idx_r    <= '0;
      open_r       <= 1'b0;
    end else begin
      pen_x_r      <= pen_x_nxt;
      pen_y_r      <= pen_y_nxt;
      phase_r      <= phase_nxt;
      tens_r       <= tens_nxt;
      pal_active_r <= pal_active_nxt;
      pal_idx_r    <= pal_idx_nxt;
      open_r       <= open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (out_valid_r && out_ready && pend_r) begin
      // The main copy of a doubled glyph has gone; turn the register into its shadow.
      pend_r       <= 1'b0;
      res_r.y      <= res_r.y - COORD_BITS'(1);
      res_r.shadow <= 1'b1;
      res_r.last   <= 1'b1;
    end else if (emit) begin
      out_valid_r <= 1'b1;
      pend_r      <= emit_pend;
      res_r       <= new_res;
    end else if (out_valid_r && out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_atlas_col    = res_r.col;
  assign out_atlas_row    = res_r.row;
  assign out_pen_x_out    = OUT_COORD_W'(res_r.x);
  assign out_pen_y_out    = OUT_COORD_W'(res_r.y);
  assign out_from_palette = res_r.from_pal;
  assign out_color_word   = res_r.color;
  assign out_is_shadow    = res_r.shadow;
  assign out_bad_escape   = res_r.bad;
  assign out_run_last     = res_r.last;

endmodule
